FILE: rtl/core/pwsc_pkg.sv
`default_nettype none

package pwsc_pkg;

    // fixed-point setup
    localparam int SPEED_FRAC_BITS = 12;
    localparam int DRIVE_LIMIT     = 255;
    localparam int US_PER_SECOND   = 1000000;

    // port widths
    localparam int GAIN_W     = 32;
    localparam int SPEED_W    = 24;
    localparam int RADIUS_W   = 16;
    localparam int DT_W       = 32;
    localparam int DUTY_W     = 8;
    localparam int STATUS_W   = 2;
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 32;

    // internal widths
    localparam int ERR_W      = SPEED_W + 1;
    localparam int DERR_W     = SPEED_W + 2;
    localparam int INTEG_W    = 48;
    localparam int INTEG_HALF = 24;
    localparam int DT_SHORT_W = 20;
    localparam int QUO_W      = 25;
    localparam int REM_W      = 44;
    localparam int OPND_W     = 33;
    localparam int PROD_W     = 64;
    localparam int ACC_W      = 64;
    localparam int LIN_SHIFT  = 16;
    localparam int CMD_SHIFT  = 16 + SPEED_FRAC_BITS;

    // one million = 2^6 * 15625; the odd part goes through a reciprocal multiply
    localparam int DIV_POW2   = 6;
    localparam int DIV_ODD    = 15625;
    localparam int Y_W        = REM_W - DIV_POW2;
    localparam int Y_LO_W     = 19;
    localparam int RCP_SHIFT  = 45;
    localparam logic [OPND_W-2:0] RCP_MUL = 32'd2251799813;

    localparam logic signed [ACC_W-1:0] TERM_LIM = 64'sh1000_0000_0000_0000;
    localparam logic signed [ACC_W-1:0] KI_BIG   = 64'sd73014444032;
    localparam logic signed [ACC_W-1:0] CMD_LIM  = ACC_W'(64'(DRIVE_LIMIT) << CMD_SHIFT);
    localparam logic [DUTY_W-1:0] DUTY_AT_LIMIT  = DUTY_W'(DRIVE_LIMIT);

    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_KP       = 3'd0,
        REG_KI       = 3'd1,
        REG_KD       = 3'd2,
        REG_SETPOINT = 3'd3,
        REG_RADIUS   = 3'd4
    } cfg_reg_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_NORMAL    = 2'd0,
        ST_HELD      = 2'd1,
        ST_STOPPED   = 2'd2,
        ST_SATURATED = 2'd3
    } status_t;

    typedef enum logic [3:0] {
        MUL_LIN,
        MUL_DT,
        MUL_RH,
        MUL_RL,
        MUL_QD,
        MUL_KP,
        MUL_KD,
        MUL_HI,
        MUL_LO
    } mul_op_t;

    typedef enum logic [4:0] {
        S_IDLE,
        S_MUL_LIN,
        S_LIN,
        S_MUL_DT,
        S_DIV_INIT,
        S_MUL_RH,
        S_MUL_RL,
        S_QEST,
        S_MUL_QD,
        S_QFIX,
        S_INTEG,
        S_MUL_KP,
        S_MUL_KD,
        S_MUL_HI,
        S_MUL_LO,
        S_KI,
        S_SUM,
        S_FIN,
        S_EMIT
    } state_t;

    typedef struct packed {
        logic    capture;
        logic    mul_en;
        mul_op_t mul_op;
        logic    lin_eval;
        logic    dt_check;
        logic    div_init;
        logic    quo_load;
        logic    quo_fix;
        logic    integ_upd;
        logic    acc_load;
        logic    acc_add;
        logic    ph_load;
        logic    term_load;
        logic    sum_add;
        logic    finish;
        logic    emit;
    } cmd_t;

    typedef struct packed {
        logic gains_zero;
        logic sp_zero;
        logic dt_long;
        logic out_free;
    } stat_t;

endpackage

`default_nettype wire

FILE: rtl/core/pwsc_ctrl.sv
`default_nettype none

module pwsc_ctrl (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           s_valid,
    output logic                s_ready,
    input  wire pwsc_pkg::stat_t stat,
    output pwsc_pkg::cmd_t      cmd
);
    import pwsc_pkg::*;

    state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        cmd.mul_op = MUL_LIN;
        s_ready    = 1'b0;
        case (state_reg)
            S_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.capture = 1'b1;
                    state_next  = S_MUL_LIN;
                end
            end
            S_MUL_LIN: begin
                cmd.mul_en = 1'b1;
                cmd.mul_op = MUL_LIN;
                state_next = S_LIN;
            end
            S_LIN: begin
                cmd.lin_eval = 1'b1;
                // held or stopped results skip the loop math
                if (stat.gains_zero || stat.sp_zero) begin
                    state_next = S_EMIT;
                end else begin
                    state_next = S_MUL_DT;
                end
            end
            S_MUL_DT: begin
                cmd.mul_en   = 1'b1;
                cmd.mul_op   = MUL_DT;
                cmd.dt_check = 1'b1;
                state_next   = stat.dt_long ? S_MUL_KP : S_DIV_INIT;
            end
            S_DIV_INIT: begin
                cmd.div_init = 1'b1;
                state_next   = S_MUL_RH;
            end
            S_MUL_RH: begin
                cmd.mul_en = 1'b1;
                cmd.mul_op = MUL_RH;
                state_next = S_MUL_RL;
            end
            S_MUL_RL: begin
                // high partial product parks in the accumulator
                cmd.mul_en   = 1'b1;
                cmd.mul_op   = MUL_RL;
                cmd.acc_load = 1'b1;
                state_next   = S_QEST;
            end
            S_QEST: begin
                cmd.quo_load = 1'b1;
                state_next   = S_MUL_QD;
            end
            S_MUL_QD: begin
                cmd.mul_en = 1'b1;
                cmd.mul_op = MUL_QD;
                state_next = S_QFIX;
            end
            S_QFIX: begin
                cmd.quo_fix = 1'b1;
                state_next  = S_INTEG;
            end
            S_INTEG: begin
                cmd.integ_upd = 1'b1;
                state_next    = S_MUL_KP;
            end
            S_MUL_KP: begin
                cmd.mul_en = 1'b1;
                cmd.mul_op = MUL_KP;
                state_next = S_MUL_KD;
            end
            S_MUL_KD: begin
                cmd.mul_en   = 1'b1;
                cmd.mul_op   = MUL_KD;
                cmd.acc_load = 1'b1;
                state_next   = S_MUL_HI;
            end
            S_MUL_HI: begin
                cmd.mul_en  = 1'b1;
                cmd.mul_op  = MUL_HI;
                cmd.acc_add = 1'b1;
                state_next  = S_MUL_LO;
            end
            S_MUL_LO: begin
                cmd.mul_en  = 1'b1;
                cmd.mul_op  = MUL_LO;
                cmd.ph_load = 1'b1;
                state_next  = S_KI;
            end
            S_KI: begin
                cmd.term_load = 1'b1;
                state_next    = S_SUM;
            end
            S_SUM: begin
                cmd.sum_add = 1'b1;
                state_next  = S_FIN;
            end
            S_FIN: begin
                cmd.finish = 1'b1;
                state_next = S_EMIT;
            end
            S_EMIT: begin
                if (stat.out_free) begin
                    cmd.emit   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

FILE: rtl/core/pwsc_datapath.sv
`default_nettype none

module pwsc_datapath (
    input  wire logic                                   aclk,
    input  wire logic                                   aresetn,
    input  wire logic                                   cfg_we,
    input  wire logic [pwsc_pkg::CFG_ADDR_W-1:0]        cfg_addr,
    input  wire logic [pwsc_pkg::CFG_DATA_W-1:0]        cfg_wdata,
    input  wire logic signed [pwsc_pkg::SPEED_W-1:0]    s_sensor_speed,
    input  wire logic [pwsc_pkg::DT_W-1:0]              s_elapsed_us,
    input  wire logic                                   m_ready,
    output logic                                        m_valid,
    output logic [pwsc_pkg::DUTY_W-1:0]                 m_cw_duty,
    output logic [pwsc_pkg::DUTY_W-1:0]                 m_ccw_duty,
    output logic signed [pwsc_pkg::SPEED_W-1:0]         m_linear_speed,
    output logic [pwsc_pkg::STATUS_W-1:0]               m_status,
    input  wire pwsc_pkg::cmd_t                         cmd,
    output pwsc_pkg::stat_t                             stat
);
    import pwsc_pkg::*;

    // configuration
    logic signed [GAIN_W-1:0]  kp_reg, ki_reg, kd_reg;
    logic signed [SPEED_W-1:0] sp_reg;
    logic [RADIUS_W-1:0]       radius_reg;

    // sample and loop state
    logic signed [SPEED_W-1:0] sensor_reg;
    logic [DT_W-1:0]           dt_reg;
    logic signed [SPEED_W-1:0] filt_reg;
    logic signed [INTEG_W-1:0] integ_reg, new_integ_reg;
    logic signed [ERR_W-1:0]   last_err_reg, err_reg;
    logic [DUTY_W-1:0]         held_cw_reg, held_ccw_reg;

    // arithmetic
    logic signed [PROD_W-1:0]  prod_reg, acc_reg, ph_reg, term_reg;
    logic [Y_W-1:0]            y_reg;
    logic [QUO_W-1:0]          quo_reg;
    logic                      neg_reg;

    // result and output register
    logic [DUTY_W-1:0]         res_cw_reg, res_ccw_reg, m_cw_reg, m_ccw_reg;
    logic signed [SPEED_W-1:0] res_lin_reg, m_lin_reg;
    status_t                   res_status_reg, m_status_reg;
    logic                      m_valid_reg;

    logic signed [OPND_W-1:0]   mul_a, mul_b;
    logic signed [2*OPND_W-1:0] mul_full;
    logic signed [SPEED_W-1:0]  lin, filt_new;
    logic signed [SPEED_W:0]    filt_sum;
    logic signed [ERR_W-1:0]    err_new;
    logic signed [DERR_W-1:0]   derr;
    logic [PROD_W-1:0]          prod_mag;
    logic [ACC_W-1:0]           rcp_sum;
    logic [QUO_W-1:0]           quo_est;
    logic [Y_W-1:0]             quo_rem;
    logic                       quo_up;
    logic signed [QUO_W-1:0]    step;
    logic signed [INTEG_W:0]    isum;
    logic signed [INTEG_W-1:0]  isat;
    logic signed [ACC_W-1:0]    ki_r, ki_term;
    logic                       sat_hi, sat_lo, sat, acc_neg;
    logic [ACC_W-1:0]           acc_mag, acc_q;
    logic [DUTY_W-1:0]          duty, cw_new, ccw_new;

    assign stat.gains_zero = (kp_reg == '0) && (ki_reg == '0) && (kd_reg == '0);
    assign stat.sp_zero    = (sp_reg == '0);
    assign stat.dt_long    = (dt_reg >= DT_W'(US_PER_SECOND));
    assign stat.out_free   = !m_valid_reg || m_ready;

    // shared multiplier operand select
    always_comb begin
        case (cmd.mul_op)
            MUL_LIN: begin
                mul_a = {{(OPND_W-SPEED_W){sensor_reg[SPEED_W-1]}}, sensor_reg};
                mul_b = {{(OPND_W-RADIUS_W){1'b0}}, radius_reg};
            end
            MUL_DT: begin
                mul_a = {{(OPND_W-ERR_W){err_reg[ERR_W-1]}}, err_reg};
                mul_b = {{(OPND_W-DT_SHORT_W){1'b0}}, dt_reg[DT_SHORT_W-1:0]};
            end
            MUL_RH: begin
                mul_a = {1'b0, RCP_MUL};
                mul_b = {{(OPND_W-(Y_W-Y_LO_W)){1'b0}}, y_reg[Y_W-1:Y_LO_W]};
            end
            MUL_RL: begin
                mul_a = {1'b0, RCP_MUL};
                mul_b = {{(OPND_W-Y_LO_W){1'b0}}, y_reg[Y_LO_W-1:0]};
            end
            MUL_QD: begin
                mul_a = {{(OPND_W-QUO_W){1'b0}}, quo_reg};
                mul_b = OPND_W'(DIV_ODD);
            end
            MUL_KP: begin
                mul_a = {kp_reg[GAIN_W-1], kp_reg};
                mul_b = {{(OPND_W-ERR_W){err_reg[ERR_W-1]}}, err_reg};
            end
            MUL_KD: begin
                mul_a = {kd_reg[GAIN_W-1], kd_reg};
                mul_b = {{(OPND_W-DERR_W){derr[DERR_W-1]}}, derr};
            end
            MUL_HI: begin
                mul_a = {ki_reg[GAIN_W-1], ki_reg};
                mul_b = {{(OPND_W-INTEG_HALF){new_integ_reg[INTEG_W-1]}},
                         new_integ_reg[INTEG_W-1:INTEG_HALF]};
            end
            MUL_LO: begin
                mul_a = {ki_reg[GAIN_W-1], ki_reg};
                mul_b = {{(OPND_W-INTEG_HALF){1'b0}}, new_integ_reg[INTEG_HALF-1:0]};
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_full = mul_a * mul_b;

    // scaling and filtering, floor rounding via arithmetic bit selects
    assign lin      = prod_reg[LIN_SHIFT+SPEED_W-1:LIN_SHIFT];
    assign filt_sum = {filt_reg[SPEED_W-1], filt_reg} + {lin[SPEED_W-1], lin};
    assign filt_new = filt_sum[SPEED_W:1];
    assign err_new  = {sp_reg[SPEED_W-1], sp_reg} - {filt_new[SPEED_W-1], filt_new};
    assign derr     = {err_reg[ERR_W-1], err_reg} - {last_err_reg[ERR_W-1], last_err_reg};

    // divide by one million: drop the power of two, reciprocal multiply for the
    // odd part in two halves, the estimate is exact or one low
    assign prod_mag = prod_reg[PROD_W-1] ? PROD_W'(-prod_reg) : PROD_W'(prod_reg);
    assign rcp_sum  = $unsigned(acc_reg) + ($unsigned(prod_reg) >> Y_LO_W);
    assign quo_est  = rcp_sum[RCP_SHIFT-Y_LO_W+QUO_W-1:RCP_SHIFT-Y_LO_W];
    assign quo_rem  = y_reg - prod_reg[Y_W-1:0];
    assign quo_up   = (quo_rem >= Y_W'(DIV_ODD));

    // integral update with 48-bit saturation
    assign step = neg_reg ? QUO_W'(-quo_reg) : QUO_W'(quo_reg);
    assign isum = {integ_reg[INTEG_W-1], integ_reg}
                + {{(INTEG_W+1-QUO_W){step[QUO_W-1]}}, step};
    always_comb begin
        if (isum[INTEG_W] != isum[INTEG_W-1]) begin
            isat = isum[INTEG_W] ? {1'b1, {(INTEG_W-1){1'b0}}} : {1'b0, {(INTEG_W-1){1'b1}}};
        end else begin
            isat = isum[INTEG_W-1:0];
        end
    end

    // integral term from its two partial products, limited to 2^60
    assign ki_r = (ph_reg <<< INTEG_HALF) + prod_reg;
    always_comb begin
        if (ph_reg > KI_BIG) begin
            ki_term = TERM_LIM;
        end else if (ph_reg < -KI_BIG) begin
            ki_term = -TERM_LIM;
        end else if (ki_r > TERM_LIM) begin
            ki_term = TERM_LIM;
        end else if (ki_r < -TERM_LIM) begin
            ki_term = -TERM_LIM;
        end else begin
            ki_term = ki_r;
        end
    end

    // clip, truncate toward zero and split by direction
    assign sat_hi  = (acc_reg > CMD_LIM);
    assign sat_lo  = (acc_reg < -CMD_LIM);
    assign sat     = sat_hi || sat_lo;
    assign acc_neg = acc_reg[ACC_W-1];
    assign acc_mag = acc_neg ? ACC_W'(-acc_reg) : ACC_W'(acc_reg);
    assign acc_q   = acc_mag >> CMD_SHIFT;
    assign duty    = sat ? DUTY_AT_LIMIT : acc_q[DUTY_W-1:0];
    assign cw_new  = acc_neg ? '0 : duty;
    assign ccw_new = acc_neg ? duty : '0;

    // configuration and loop state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            kp_reg       <= '0;
            ki_reg       <= '0;
            kd_reg       <= '0;
            sp_reg       <= '0;
            radius_reg   <= '0;
            filt_reg     <= '0;
            integ_reg    <= '0;
            last_err_reg <= '0;
            held_cw_reg  <= '0;
            held_ccw_reg <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            if (cfg_we) begin
                case (cfg_addr)
                    REG_KP:       kp_reg     <= cfg_wdata[GAIN_W-1:0];
                    REG_KI:       ki_reg     <= cfg_wdata[GAIN_W-1:0];
                    REG_KD:       kd_reg     <= cfg_wdata[GAIN_W-1:0];
                    REG_SETPOINT: sp_reg     <= cfg_wdata[SPEED_W-1:0];
                    REG_RADIUS:   radius_reg <= cfg_wdata[RADIUS_W-1:0];
                    default: ;
                endcase
            end
            if (cmd.lin_eval && !stat.gains_zero) begin
                filt_reg <= filt_new;
                if (stat.sp_zero) begin
                    integ_reg    <= '0;
                    last_err_reg <= '0;
                    held_cw_reg  <= '0;
                    held_ccw_reg <= '0;
                end
            end
            if (cmd.finish) begin
                // a clipped command backs out the step just added
                if (!(sat && !stat.dt_long)) begin
                    integ_reg <= new_integ_reg;
                end
                last_err_reg <= err_reg;
                held_cw_reg  <= cw_new;
                held_ccw_reg <= ccw_new;
            end
            if (cmd.emit) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // working registers
    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            sensor_reg <= s_sensor_speed;
            dt_reg     <= s_elapsed_us;
        end
        if (cmd.mul_en) begin
            prod_reg <= mul_full[PROD_W-1:0];
        end
        if (cmd.lin_eval) begin
            res_lin_reg <= lin;
            if (stat.gains_zero) begin
                res_cw_reg     <= held_cw_reg;
                res_ccw_reg    <= held_ccw_reg;
                res_status_reg <= ST_HELD;
            end else if (stat.sp_zero) begin
                res_cw_reg     <= '0;
                res_ccw_reg    <= '0;
                res_status_reg <= ST_STOPPED;
            end else begin
                err_reg <= err_new;
            end
        end
        if (cmd.dt_check && stat.dt_long) begin
            new_integ_reg <= '0;
        end
        if (cmd.div_init) begin
            neg_reg <= prod_reg[PROD_W-1];
            y_reg   <= prod_mag[REM_W-1:DIV_POW2];
        end
        if (cmd.quo_load) begin
            quo_reg <= quo_est;
        end else if (cmd.quo_fix) begin
            quo_reg <= quo_reg + QUO_W'(quo_up);
        end
        if (cmd.integ_upd) begin
            new_integ_reg <= isat;
        end
        if (cmd.acc_load) begin
            acc_reg <= prod_reg;
        end else if (cmd.acc_add) begin
            acc_reg <= acc_reg + prod_reg;
        end else if (cmd.sum_add) begin
            acc_reg <= acc_reg + term_reg;
        end
        if (cmd.ph_load) begin
            ph_reg <= prod_reg;
        end
        if (cmd.term_load) begin
            term_reg <= ki_term;
        end
        if (cmd.finish) begin
            res_cw_reg     <= cw_new;
            res_ccw_reg    <= ccw_new;
            res_status_reg <= sat ? ST_SATURATED : ST_NORMAL;
        end
        if (cmd.emit) begin
            m_cw_reg     <= res_cw_reg;
            m_ccw_reg    <= res_ccw_reg;
            m_lin_reg    <= res_lin_reg;
            m_status_reg <= res_status_reg;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_cw_duty      = m_cw_reg;
    assign m_ccw_duty     = m_ccw_reg;
    assign m_linear_speed = m_lin_reg;
    assign m_status       = m_status_reg;

endmodule

`default_nettype wire

FILE: rtl/core/pid_wheel_speed_controller_core.sv
// wheel speed pid controller with anti-windup
// - config port: cfg_we writes cfg_wdata into register cfg_addr (0 kp, 1 ki, 2 kd,
//   3 setpoint, 4 wheel radius); write only while the block is idle
// - input channel s_*: one item per control tick, angular speed and elapsed time
// - result channel m_*: cw/ccw duties, scaled linear speed and status for each item
// - one item is in flight at a time; s_ready is high only while the sequencer idles
// - full loop update: nine passes through the one shared 33x33 multiplier, three
//   of them for the divide by one million (reciprocal multiply plus a one-step
//   correction) that gives the integral step; the next item is taken only after
//   the result of the last one has been handed to the output register
// - elapsed time of one second or more skips the divide
// - all gains zero or a zero setpoint: the loop math is skipped
// - the result sits in an output register; a stalled receiver only delays the
//   final hand-over, the sequencer waits there with the result held and then
//   accepts the next item as soon as the output register is free
// - reset (aresetn low, synchronous) clears gains, setpoint, radius, the filtered
//   speed, integral, last error, held duties and the output valid flag
`default_nettype none

module pid_wheel_speed_controller_core (
    input  wire logic                                   aclk,
    input  wire logic                                   aresetn,
    // configuration
    input  wire logic                                   cfg_we,
    input  wire logic [pwsc_pkg::CFG_ADDR_W-1:0]        cfg_addr,
    input  wire logic [pwsc_pkg::CFG_DATA_W-1:0]        cfg_wdata,
    // sample input
    input  wire logic                                   s_valid,
    output logic                                        s_ready,
    input  wire logic signed [pwsc_pkg::SPEED_W-1:0]    s_sensor_speed,
    input  wire logic [pwsc_pkg::DT_W-1:0]              s_elapsed_us,
    // drive result
    output logic                                        m_valid,
    input  wire logic                                   m_ready,
    output logic [pwsc_pkg::DUTY_W-1:0]                 m_cw_duty,
    output logic [pwsc_pkg::DUTY_W-1:0]                 m_ccw_duty,
    output logic signed [pwsc_pkg::SPEED_W-1:0]         m_linear_speed,
    output logic [pwsc_pkg::STATUS_W-1:0]               m_status
);
    import pwsc_pkg::*;

    // sequencer to datapath commands and datapath flags back
    cmd_t  cmd;
    stat_t stat;

    // state machine: walks multiply, divide and accumulate steps
    pwsc_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    // config registers, loop state, shared multiplier, divider, output register
    pwsc_datapath u_datapath (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_we         (cfg_we),
        .cfg_addr       (cfg_addr),
        .cfg_wdata      (cfg_wdata),
        .s_sensor_speed (s_sensor_speed),
        .s_elapsed_us   (s_elapsed_us),
        .m_ready        (m_ready),
        .m_valid        (m_valid),
        .m_cw_duty      (m_cw_duty),
        .m_ccw_duty     (m_ccw_duty),
        .m_linear_speed (m_linear_speed),
        .m_status       (m_status),
        .cmd            (cmd),
        .stat           (stat)
    );

endmodule

`default_nettype wire

FILE: rtl/core/pwsc_checker.sv
`default_nettype none

module pwsc_checker (
    input wire logic                                   aclk,
    input wire logic                                   aresetn,
    input wire logic                                   s_valid,
    input wire logic                                   s_ready,
    input wire logic                                   m_valid,
    input wire logic                                   m_ready,
    input wire logic [pwsc_pkg::DUTY_W-1:0]            m_cw_duty,
    input wire logic [pwsc_pkg::DUTY_W-1:0]            m_ccw_duty,
    input wire logic signed [pwsc_pkg::SPEED_W-1:0]    m_linear_speed,
    input wire logic [pwsc_pkg::STATUS_W-1:0]          m_status
);
    import pwsc_pkg::*;

    // one item at a time: no back-to-back accept
    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("input accepted on consecutive cycles");

    // never drive both directions at once
    a_one_direction: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_cw_duty == '0 || m_ccw_duty == '0))
        else $error("both duties nonzero");

    // zero setpoint stops the wheel
    a_stop_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_status == ST_STOPPED) |-> (m_cw_duty == '0 && m_ccw_duty == '0))
        else $error("stopped status with nonzero duty");

    // a held result stays put while the receiver stalls
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_cw_duty) && $stable(m_ccw_duty)
                                   && $stable(m_linear_speed) && $stable(m_status)))
        else $error("result changed while stalled");

endmodule

bind pid_wheel_speed_controller_core pwsc_checker u_pwsc_checker (.*);

`default_nettype wire

FILE: verif/pid_wheel_speed_controller_core_tb.sv
`timescale 1ns / 1ps

module pid_wheel_speed_controller_core_tb;
    import pwsc_pkg::*;

    // run control
    localparam int RESULT_LATENCY = 38;
    localparam int WATCHDOG_LIMIT = 1000;
    localparam int REPORT_LIMIT   = 10;
    localparam int RESET_CYCLES   = 9;
    localparam int RANDOM_PHASES  = 12;
    localparam int QUIET_PHASES   = 2;
    localparam int PHASE_ITEMS    = 135;

    // fixed-point constants of the control law, kept apart from the design's own
    localparam longint ONE_SECOND_US = 64'sd1000000;
    localparam int     CMD_FRAC      = 28;
    localparam longint CMD_CAP       = 64'sd255 <<< CMD_FRAC;
    localparam longint DUTY_MAX      = 64'sd255;
    localparam longint INTEG_TOP     = 64'sh0000_7FFF_FFFF_FFFF;
    localparam longint INTEG_BOT     = -INTEG_TOP - 64'sd1;
    localparam longint KI_TERM_CAP   = 64'sd1 <<< 60;
    localparam longint KI_PART_CAP   = (64'sd1 <<< 36) + (64'sd1 <<< 32);

    typedef struct {
        logic [DUTY_W-1:0]         cw;
        logic [DUTY_W-1:0]         ccw;
        logic signed [SPEED_W-1:0] lin;
        status_t                   status;
    } drive_result_t;

    // drive predictor plus the queue of drive items still owed by the block
    class drive_scoreboard;
        logic signed [GAIN_W-1:0]  kp, ki, kd;
        logic signed [SPEED_W-1:0] setpoint;
        logic [RADIUS_W-1:0]       radius;
        longint                    filt_speed, integ, last_err;
        logic [DUTY_W-1:0]         held_cw, held_ccw;
        drive_result_t             owed_q[$];
        int                        errors;

        function new();
            kp = '0;
            ki = '0;
            kd = '0;
            setpoint = '0;
            radius = '0;
            filt_speed = 0;
            integ = 0;
            last_err = 0;
            held_cw = '0;
            held_ccw = '0;
            errors = 0;
        endfunction

        function void write_reg(logic [CFG_ADDR_W-1:0] addr, logic [CFG_DATA_W-1:0] data);
            case (addr)
                REG_KP:       kp = data;
                REG_KI:       ki = data;
                REG_KD:       kd = data;
                REG_SETPOINT: setpoint = data[SPEED_W-1:0];
                REG_RADIUS:   radius = data[RADIUS_W-1:0];
                default:      ;
            endcase
        endfunction

        // ki times integral, split in high and low halves, capped at 2^60
        function longint ki_product(longint acc);
            longint lo, hi, part, r;
            lo = acc & 64'sh0000_0000_00FF_FFFF;
            hi = (acc - lo) >>> 24;
            part = longint'(ki) * hi;
            if (part > KI_PART_CAP) return KI_TERM_CAP;
            if (part < -KI_PART_CAP) return -KI_TERM_CAP;
            r = (part <<< 24) + longint'(ki) * lo;
            if (r > KI_TERM_CAP) r = KI_TERM_CAP;
            if (r < -KI_TERM_CAP) r = -KI_TERM_CAP;
            return r;
        endfunction

        function drive_result_t predict_drive(logic signed [SPEED_W-1:0] sensor,
                                              logic [DT_W-1:0] dt);
            drive_result_t r;
            longint lin, err, step, nv, added, sum, cmd;
            lin = (longint'(sensor) * longint'(radius)) >>> 16;
            r.lin = SPEED_W'(lin);

            // no gains: nothing moves, the last duties are repeated
            if (kp == 0 && ki == 0 && kd == 0) begin
                r.cw = held_cw;
                r.ccw = held_ccw;
                r.status = ST_HELD;
                return r;
            end

            filt_speed = (filt_speed + lin) >>> 1;

            // zero setpoint: stop and forget the loop history
            if (setpoint == 0) begin
                integ = 0;
                last_err = 0;
                held_cw = '0;
                held_ccw = '0;
                r.cw = '0;
                r.ccw = '0;
                r.status = ST_STOPPED;
                return r;
            end

            err = longint'(setpoint) - filt_speed;
            added = 0;
            if (longint'(dt) < ONE_SECOND_US) begin
                step = (err * longint'(dt)) / ONE_SECOND_US;
                nv = integ + step;
                if (nv > INTEG_TOP) nv = INTEG_TOP;
                if (nv < INTEG_BOT) nv = INTEG_BOT;
                added = nv - integ;
                integ = nv;
            end else begin
                integ = 0;
            end

            sum = longint'(kp) * err + ki_product(integ) + longint'(kd) * (err - last_err);
            r.status = ST_NORMAL;
            if (sum > CMD_CAP) begin
                cmd = DUTY_MAX;
                integ = integ - added;
                r.status = ST_SATURATED;
            end else if (sum < -CMD_CAP) begin
                cmd = -DUTY_MAX;
                integ = integ - added;
                r.status = ST_SATURATED;
            end else begin
                cmd = (sum >= 0) ? (sum >>> CMD_FRAC) : -((-sum) >>> CMD_FRAC);
            end
            last_err = err;

            if (cmd >= 0) begin
                held_cw = DUTY_W'(cmd);
                held_ccw = '0;
            end else begin
                held_cw = '0;
                held_ccw = DUTY_W'(-cmd);
            end
            r.cw = held_cw;
            r.ccw = held_ccw;
            return r;
        endfunction

        function void note_sample(logic signed [SPEED_W-1:0] sensor, logic [DT_W-1:0] dt);
            owed_q.push_back(predict_drive(sensor, dt));
        endfunction

        function void check_drive(drive_result_t got);
            drive_result_t want;
            if (owed_q.size() == 0) begin
                errors++;
                if (errors <= REPORT_LIMIT)
                    $display("drive item with none owed: cw %0d ccw %0d lin %0d st %0d",
                             got.cw, got.ccw, got.lin, got.status);
                return;
            end
            want = owed_q.pop_front();
            if (got.cw !== want.cw || got.ccw !== want.ccw || got.lin !== want.lin
                    || got.status !== want.status) begin
                errors++;
                if (errors <= REPORT_LIMIT)
                    $display("drive mismatch: want cw %0d ccw %0d lin %0d st %0d, %s",
                             want.cw, want.ccw, want.lin, want.status,
                             $sformatf("got cw %0d ccw %0d lin %0d st %0d",
                                       got.cw, got.ccw, got.lin, got.status));
            end
        endfunction

        function int pending();
            return owed_q.size();
        endfunction

        function int failures();
            return errors + owed_q.size();
        endfunction
    endclass

    // block ports, all inputs known from time zero
    logic                        aclk = 1'b0;
    logic                        aresetn = 1'b0;
    logic                        cfg_we = 1'b0;
    logic [CFG_ADDR_W-1:0]       cfg_addr = '0;
    logic [CFG_DATA_W-1:0]       cfg_wdata = '0;
    logic                        s_valid = 1'b0;
    logic                        s_ready;
    logic signed [SPEED_W-1:0]   s_sensor_speed = '0;
    logic [DT_W-1:0]             s_elapsed_us = '0;
    logic                        m_valid;
    logic                        m_ready = 1'b0;
    logic [DUTY_W-1:0]           m_cw_duty;
    logic [DUTY_W-1:0]           m_ccw_duty;
    logic signed [SPEED_W-1:0]   m_linear_speed;
    logic [STATUS_W-1:0]         m_status;

    // idle odds in percent per item / per cycle, changed between phases
    int gap_pct = 0;
    int stall_pct = 0;

    drive_scoreboard sb = new();

    pid_wheel_speed_controller_core dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_we         (cfg_we),
        .cfg_addr       (cfg_addr),
        .cfg_wdata      (cfg_wdata),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_sensor_speed (s_sensor_speed),
        .s_elapsed_us   (s_elapsed_us),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_cw_duty      (m_cw_duty),
        .m_ccw_duty     (m_ccw_duty),
        .m_linear_speed (m_linear_speed),
        .m_status       (m_status)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    // sample item: optional idle burst first, then hold valid until taken
    task automatic send_sample(input logic signed [SPEED_W-1:0] speed,
                               input logic [DT_W-1:0] dt);
        if (gap_pct > 0 && $urandom_range(0, 99) < gap_pct) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_sensor_speed <= speed;
        s_elapsed_us <= dt;
        do @(posedge aclk); while (s_ready !== 1'b1);
        sb.note_sample(speed, dt);
    endtask

    // drop valid and wait until every owed item is back and the block takes input
    task automatic wait_idle();
        s_valid <= 1'b0;
        while (sb.pending() != 0 || s_ready !== 1'b1) @(posedge aclk);
    endtask

    // one register write per cycle, write enable left high for the caller to drop
    task automatic put_reg(input logic [CFG_ADDR_W-1:0] addr, input logic [CFG_DATA_W-1:0] data);
        cfg_we <= 1'b1;
        cfg_addr <= addr;
        cfg_wdata <= data;
        sb.write_reg(addr, data);
        @(posedge aclk);
    endtask

    task automatic program_regs(input logic [GAIN_W-1:0] kp, input logic [GAIN_W-1:0] ki,
                                input logic [GAIN_W-1:0] kd, input logic [SPEED_W-1:0] sp,
                                input logic [RADIUS_W-1:0] rad);
        wait_idle();
        put_reg(REG_KP, kp);
        put_reg(REG_KI, ki);
        put_reg(REG_KD, kd);
        put_reg(REG_SETPOINT, CFG_DATA_W'(sp));
        put_reg(REG_RADIUS, CFG_DATA_W'(rad));
        cfg_we <= 1'b0;
    endtask

    // gain in +-2^span_bits most of the time, sometimes an extreme or anything
    function automatic logic [GAIN_W-1:0] pick_gain(int span_bits);
        case ($urandom_range(0, 11))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return 32'd0;
            3: return 32'($urandom);
            default: return 32'(int'($urandom_range(0, 2 << span_bits)) - (1 << span_bits));
        endcase
    endfunction

    // result side: check every taken item, stall in random bursts
    initial begin : result_sink
        int hold;
        drive_result_t got;
        hold = 0;
        forever begin
            @(posedge aclk);
            if (aresetn && m_valid === 1'b1 && m_ready === 1'b1) begin
                got.cw = m_cw_duty;
                got.ccw = m_ccw_duty;
                got.lin = m_linear_speed;
                got.status = status_t'(m_status);
                sb.check_drive(got);
            end
            if (hold > 0) begin
                hold--;
                m_ready <= 1'b0;
            end else if (stall_pct > 0 && $urandom_range(0, 99) < stall_pct) begin
                hold = $urandom_range(0, 17);
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // give up when no item moves on either side for too long
    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT) begin
            @(posedge aclk);
            if ((s_valid === 1'b1 && s_ready === 1'b1) || (m_valid === 1'b1 && m_ready === 1'b1))
                quiet = 0;
            else
                quiet++;
        end
        $display("CHECK FAILED");
        $finish;
    end

    initial begin : stimulus
        logic [GAIN_W-1:0]         kp, ki, kd;
        logic signed [SPEED_W-1:0] sp, speed, centre;
        logic [RADIUS_W-1:0]       rad;
        logic [DT_W-1:0]           dt;
        int                        pick;

        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // gains still at reset: every item is held with zero duties
        send_sample(24'sh7FFFFF, 32'd0);
        send_sample(24'sh800000, 32'hFFFF_FFFF);
        send_sample(24'sh000000, 32'd999999);

        // full radius, gains still zero: linear speed extremes while held
        program_regs(32'd0, 32'd0, 32'd0, 24'd0, 16'hFFFF);
        send_sample(24'sh7FFFFF, 32'd1000);
        send_sample(24'sh800000, 32'd1000);

        // writes to the unused indexes must leave every register alone
        wait_idle();
        for (int a = int'(REG_RADIUS) + 1; a < (1 << CFG_ADDR_W); a++)
            put_reg(CFG_ADDR_W'(a), '1);
        cfg_we <= 1'b0;
        send_sample(24'sh001000, 32'd1000);

        // zero setpoint with a live gain: stopped
        program_regs(32'h0010_0000, 32'd0, 32'd0, 24'd0, 16'h8000);
        send_sample(24'sh004000, 32'd1000);
        send_sample(-24'sh004000, 32'd1000000);

        // moderate loop, elapsed time at its edges including the integral clear
        program_regs(32'h0010_0000, 32'h0001_0000, 32'h0004_0000, 24'sh004000, 16'h8000);
        send_sample(24'sh002000, 32'd0);
        send_sample(24'sh002000, 32'd999999);
        send_sample(24'sh003000, 32'd1000000);
        send_sample(24'sh001000, 32'hFFFF_FFFF);
        send_sample(-24'sh001000, 32'd5000);

        // clipping at both limits, with and without an integral step to back out
        program_regs(32'h7FFF_FFFF, 32'd0, 32'd0, 24'sh004000, 16'h8000);
        send_sample(24'sh000000, 32'd2000);
        send_sample(24'sh000000, 32'd1000000);
        program_regs(32'h8000_0000, 32'd0, 32'd0, 24'sh004000, 16'h8000);
        send_sample(24'sh000000, 32'd2000);
        send_sample(24'sh000000, 32'd1000000);

        // setpoint extremes against the opposite sensor extreme
        program_regs(32'h0001_0000, 32'h7FFF_FFFF, 32'h8000_0000, 24'sh7FFFFF, 16'hFFFF);
        send_sample(24'sh800000, 32'd999999);
        program_regs(32'h0001_0000, 32'h7FFF_FFFF, 32'h8000_0000, 24'sh800000, 16'hFFFF);
        send_sample(24'sh7FFFFF, 32'd999999);

        // smallest nonzero values everywhere, negative rounding
        program_regs(32'hFFFF_FFFF, 32'd1, 32'd1, 24'sh000001, 16'd1);
        send_sample(24'sh000001, 32'd1);
        send_sample(-24'sh000001, 32'd500000);

        // wind the integral up under a tiny ki, then switch to huge ki so the
        // ki term hits its cap, first through the low half then outright
        gap_pct = 20;
        stall_pct = 10;
        program_regs(32'd0, 32'd1, 32'd0, 24'sh7FFFFF, 16'd0);
        repeat (66) send_sample(24'($urandom), 32'd999999);
        program_regs(32'd0, 32'h7FFF_FFFF, 32'd0, 24'sh7FFFFF, 16'd0);
        repeat (3) send_sample(24'($urandom), 32'd999999);
        program_regs(32'd0, 32'd1, 32'd0, 24'sh7FFFFF, 16'd0);
        repeat (12) send_sample(24'($urandom), 32'd999999);
        program_regs(32'd0, 32'h7FFF_FFFF, 32'd0, 24'sh7FFFFF, 16'd0);
        repeat (3) send_sample(24'($urandom), 32'd999999);
        program_regs(32'd0, 32'h8000_0000, 32'd0, 24'sh7FFFFF, 16'd0);
        repeat (3) send_sample(24'($urandom), 32'd999999);

        // random phases: mostly a tuned loop tracking a speed near a centre
        for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
            if (ph >= RANDOM_PHASES - QUIET_PHASES) begin
                gap_pct = 0;
                stall_pct = 0;
            end else begin
                case ($urandom_range(0, 3))
                    0: gap_pct = 0;
                    1: gap_pct = 5;
                    2: gap_pct = 20;
                    default: gap_pct = 50;
                endcase
                case ($urandom_range(0, 3))
                    0: stall_pct = 0;
                    1: stall_pct = 3;
                    2: stall_pct = 10;
                    default: stall_pct = 30;
                endcase
            end

            kp = pick_gain(22);
            ki = pick_gain(18);
            kd = pick_gain(20);
            sp = 24'(int'($urandom_range(0, 1 << 17)) - (1 << 16));
            rad = 16'($urandom);
            pick = $urandom_range(0, 9);
            case (pick)
                0: begin
                    kp = '0;
                    ki = '0;
                    kd = '0;
                end
                1: sp = '0;
                2: begin
                    kp = 32'($urandom);
                    ki = 32'($urandom);
                    kd = 32'($urandom);
                    sp = 24'($urandom);
                end
                default: ;
            endcase
            case ($urandom_range(0, 7))
                0: rad = 16'd0;
                1: rad = 16'hFFFF;
                default: ;
            endcase
            program_regs(kp, ki, kd, sp, rad);

            centre = 24'(int'($urandom_range(0, 1 << 16)) - (1 << 15));
            repeat (PHASE_ITEMS) begin
                pick = $urandom_range(0, 99);
                if (pick < 60) begin
                    speed = centre + 24'(int'($urandom_range(0, 2048)) - 1024);
                end else if (pick < 85) begin
                    speed = 24'($urandom);
                end else begin
                    case ($urandom_range(0, 3))
                        0: speed = 24'sh7FFFFF;
                        1: speed = 24'sh800000;
                        2: speed = 24'sh000000;
                        default: speed = -24'sh000001;
                    endcase
                end

                pick = $urandom_range(0, 99);
                if (pick < 65)
                    dt = $urandom_range(100, 20000);
                else if (pick < 75)
                    dt = '0;
                else if (pick < 82)
                    dt = $urandom_range(999999, 1000000);
                else if (pick < 90)
                    dt = $urandom_range(1000000, 3000000);
                else
                    dt = $urandom;
                send_sample(speed, dt);
            end
        end

        // drain, then leave room for any stray item
        wait_idle();
        repeat (RESULT_LATENCY + 8) @(posedge aclk);
        if (sb.failures() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

FILE: sim.f
rtl/core/pwsc_pkg.sv
rtl/core/pwsc_ctrl.sv
rtl/core/pwsc_datapath.sv
rtl/core/pid_wheel_speed_controller_core.sv
rtl/core/pwsc_checker.sv
verif/pid_wheel_speed_controller_core_tb.sv
